// ----- rtl/pmfb_pkg.sv -----
// shared types and codes for the paged monochrome framebuffer engine
// no dependencies
`default_nettype none

package pmfb_pkg;

  localparam int CoordW = 12;

  typedef enum logic [2:0] {
    KIND_SET       = 3'd0,
    KIND_CLEAR     = 3'd1,
    KIND_INVERT    = 3'd2,
    KIND_READ_PIX  = 3'd3,
    KIND_READ_BYTE = 3'd4,
    KIND_CLEAR_ALL = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MODIFY
  } state_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [CoordW-1:0] col;
    logic signed [CoordW-1:0] row;
  } item_t;

  typedef struct packed {
    logic       pixel_bit;
    logic [7:0] page_byte;
    logic       clipped;
  } result_t;

  // decoded item, handed from the coordinate decoder to the control
  typedef struct packed {
    kind_e      kind;
    logic       mem_op;
    logic       clip;
    logic [2:0] bit_sel;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/pmfb_item_if.sv -----
// input channel of the framebuffer engine: valid, ready and one item
// depends on pmfb_pkg
`default_nettype none

interface pmfb_item_if;
  logic             valid;
  logic             ready;
  pmfb_pkg::item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/pmfb_result_if.sv -----
// result channel of the framebuffer engine: valid, ready and one result
// depends on pmfb_pkg
`default_nettype none

interface pmfb_result_if;
  logic              valid;
  logic              ready;
  pmfb_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/pmfb_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module pmfb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/pmfb_decode.sv -----
// coordinate decoder: clip test, store address and bit select of one item
// depends on pmfb_pkg
`default_nettype none

module pmfb_decode #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int ADDR_W        = 10
) (
  input  pmfb_pkg::item_t     item_i,
  output pmfb_pkg::ctrl_t     ctrl_o,
  output logic [ADDR_W-1:0]   addr_o
);
  import pmfb_pkg::*;

  localparam logic [CoordW-1:0] ColLim = CoordW'(SCREEN_WIDTH);
  localparam logic [CoordW-1:0] RowLim = CoordW'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] RowPitch = ADDR_W'(SCREEN_WIDTH);

  logic [CoordW-1:0] col_u;
  logic [CoordW-1:0] row_u;
  logic              on_screen;
  logic [ADDR_W-1:0] page;

  assign col_u = item_i.col;
  assign row_u = item_i.row;

  // negative coordinates have the sign bit set and fail first
  assign on_screen = !col_u[CoordW-1] && !row_u[CoordW-1] &&
                     (col_u < ColLim) && (row_u < RowLim);

  assign page   = ADDR_W'(row_u[CoordW-1:3]);
  assign addr_o = ADDR_W'(page * RowPitch) + ADDR_W'(col_u);

  always_comb begin
    ctrl_o.kind    = kind_e'(item_i.kind);
    ctrl_o.bit_sel = row_u[2:0];
    case (item_i.kind) inside
      KIND_SET, KIND_CLEAR, KIND_INVERT, KIND_READ_PIX, KIND_READ_BYTE: begin
        ctrl_o.mem_op = 1'b1;
        ctrl_o.clip   = !on_screen;
      end
      default: begin
        ctrl_o.mem_op = 1'b0;
        ctrl_o.clip   = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/paged_mono_framebuffer_engine_unit.sv -----
// top level of the paged monochrome framebuffer engine
// depends on pmfb_pkg, pmfb_item_if, pmfb_result_if, pmfb_ram, pmfb_decode
`default_nettype none

// Paged monochrome frame store of SCREEN_WIDTH x SCREEN_HEIGHT pixels, kept
// as ceil(SCREEN_HEIGHT/8) pages of SCREEN_WIDTH column bytes in one
// synchronous ram; bit row%8 of byte [row/8][col] is the pixel. Each item
// sets, clears, inverts or reads one pixel, reads one page byte, or clears
// the whole store; the two unused kind codes do nothing. Each item gives
// exactly one result. A pixel or byte item issues its ram read at
// acceptance, then does modify, write back and load of the result register,
// waiting while the output register is still full; the next item is taken
// once that result is in the output register, even if it has not been taken
// yet. Clear-all and reset both run a sweep that writes zero to one byte per
// cycle, during which no item is accepted. Off-screen pixel or byte items
// leave the store alone and report clipped with zero data.

module paged_mono_framebuffer_engine_unit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pmfb_item_if.sink            item_i,
  pmfb_result_if.source        result_o
);
  import pmfb_pkg::*;

  // store geometry
  localparam int PageCount = (SCREEN_HEIGHT + 7) / 8;
  localparam int Depth     = PageCount * SCREEN_WIDTH;
  localparam int AddrW     = $clog2(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  // control state
  state_e            state_q, state_d;
  logic [AddrW-1:0]  sweep_cnt_q, sweep_cnt_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_data_q, out_data_d;

  // item held while its ram read completes
  ctrl_t             ctrl_q, ctrl_d;
  logic [AddrW-1:0]  addr_q, addr_d;

  // decoder outputs
  ctrl_t             dec_ctrl;
  logic [AddrW-1:0]  dec_addr;

  // ram port
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [7:0]        mem_rdata;

  // datapath
  logic              accept;
  logic              finish;
  logic [7:0]        bit_mask;
  logic [7:0]        new_byte;
  result_t           res;

  pmfb_decode #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (AddrW)
  ) u_decode (
    .item_i (item_i.payload),
    .ctrl_o (dec_ctrl),
    .addr_o (dec_addr)
  );

  pmfb_ram #(
    .WIDTH  (8),
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (dec_addr),
    .rdata_o (mem_rdata)
  );

  // one item in flight; the ram read is issued in the accept cycle
  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign mem_re       = accept;

  // result leaves the modify state once the output register is free
  assign finish = (state_q == ST_MODIFY) && (!out_valid_q || result_o.ready);

  // read-modify of the addressed byte; read data holds while stalled
  assign bit_mask = 8'(1) << ctrl_q.bit_sel;

  always_comb begin
    case (ctrl_q.kind)
      KIND_SET:    new_byte = mem_rdata | bit_mask;
      KIND_CLEAR:  new_byte = mem_rdata & ~bit_mask;
      KIND_INVERT: new_byte = mem_rdata ^ bit_mask;
      default:     new_byte = mem_rdata;
    endcase
  end

  always_comb begin
    res = '0;
    if (ctrl_q.mem_op) begin
      if (ctrl_q.clip) begin
        res.clipped = 1'b1;
      end else begin
        res.pixel_bit = mem_rdata[ctrl_q.bit_sel];
        res.page_byte = new_byte;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_cnt_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (finish) begin
          state_d = (ctrl_q.kind == KIND_CLEAR_ALL) ? ST_SWEEP : ST_IDLE;
        end
      end
      default: state_d = ST_SWEEP;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = new_byte;
    sweep_cnt_d = '0;
    ctrl_d      = ctrl_q;
    addr_d      = addr_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !result_o.ready;
    case (state_q)
      ST_SWEEP: begin
        mem_we      = 1'b1;
        mem_waddr   = sweep_cnt_q;
        mem_wdata   = '0;
        sweep_cnt_d = sweep_cnt_q + AddrW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          ctrl_d = dec_ctrl;
          addr_d = dec_addr;
        end
      end
      ST_MODIFY: begin
        if (finish) begin
          mem_we      = ctrl_q.mem_op && !ctrl_q.clip;
          out_valid_d = 1'b1;
          out_data_d  = res;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ctrl_q     <= ctrl_d;
    addr_q     <= addr_d;
    out_data_q <= out_data_d;
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_data_q;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for paged_mono_framebuffer_engine_unit
// depends on pmfb_pkg, pmfb_item_if, pmfb_result_if and the engine rtl
`timescale 1ns / 1ps

module tb_top;
  import pmfb_pkg::*;

  localparam int WIDTH      = 128;
  localparam int HEIGHT     = 64;
  localparam int PAGES      = (HEIGHT + 7) / 8;
  localparam int STORE_SIZE = PAGES * WIDTH;
  localparam int RAND_ITEMS = 500;
  localparam int TAIL_WAIT  = 20;
  localparam int MAX_CYCLES = 400000;
  localparam int MAX_REPORTS = 30;

  // kind codes the package leaves unnamed; the engine must treat them as no-ops
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // mirror of the frame store plus the queue of results still owed by the engine
  class frame_mirror;
    logic [7:0] page_mem [STORE_SIZE];
    result_t    pixel_results_q [$];
    int         errors;
    int         checked;
    int         clipped_seen;
    int         kind_count [8];

    function new();
      foreach (page_mem[i]) page_mem[i] = '0;
      errors = 0;
      checked = 0;
      clipped_seen = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function int pending();
      return pixel_results_q.size();
    endfunction

    // one item against the mirrored store, giving the result it must produce
    function result_t apply_op(item_t it);
      result_t    r;
      int         c;
      int         rw;
      int         idx;
      logic [7:0] mask;
      logic [7:0] b;
      r  = '0;
      c  = $signed(it.col);
      rw = $signed(it.row);
      case (it.kind)
        KIND_CLEAR_ALL: begin
          foreach (page_mem[i]) page_mem[i] = '0;
        end
        KIND_SET, KIND_CLEAR, KIND_INVERT, KIND_READ_PIX, KIND_READ_BYTE: begin
          if (c < 0 || c >= WIDTH || rw < 0 || rw >= HEIGHT) begin
            r.clipped = 1'b1;
          end else begin
            idx  = (rw >>> 3) * WIDTH + c;
            mask = 8'h01 << rw[2:0];
            b    = page_mem[idx];
            r.pixel_bit = |(b & mask);
            case (it.kind)
              KIND_SET:    b = b | mask;
              KIND_CLEAR:  b = b & ~mask;
              KIND_INVERT: b = b ^ mask;
              default: ;
            endcase
            page_mem[idx] = b;
            r.page_byte   = b;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void take_item(item_t it);
      kind_count[it.kind]++;
      pixel_results_q.push_back(apply_op(it));
    endfunction

    function void flag(string field, int exp_v, int got_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pixel_results_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      exp_r = pixel_results_q.pop_front();
      checked++;
      if (got.clipped) clipped_seen++;
      if (got.pixel_bit !== exp_r.pixel_bit) flag("pixel_bit", exp_r.pixel_bit, got.pixel_bit);
      if (got.page_byte !== exp_r.page_byte) flag("page_byte", exp_r.page_byte, got.page_byte);
      if (got.clipped !== exp_r.clipped) flag("clipped", exp_r.clipped, got.clipped);
    endfunction

    function void check_drained();
      if (pixel_results_q.size() != 0) begin
        errors++;
        $display("%0t: %0d results never arrived, expected 0 left, got %0d",
                 $time, pixel_results_q.size(), pixel_results_q.size());
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pmfb_item_if   item_if ();
  pmfb_result_if res_if ();

  frame_mirror mirror;

  int unsigned cyc_count = 0;
  int unsigned rx_tick = 0;
  int          hot_col = 0;

  always #5 clk_i = ~clk_i;

  paged_mono_framebuffer_engine_unit #(
    .SCREEN_WIDTH (WIDTH),
    .SCREEN_HEIGHT(HEIGHT)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if)
  );

  // watchdog: ends the run as failed once MAX_CYCLES is reached
  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count == MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc_count,
               mirror.pending());
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver back-pressure: rx_tick[8:7] rotates it between always ready,
  // coin-flip, one-in-eight and a square wave, so stalls hit every phase
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_tick[8:7])
      2'd0: res_if.ready <= 1'b1;
      2'd1: res_if.ready <= 1'($urandom_range(0, 1));
      2'd2: res_if.ready <= (rx_tick[2:0] == 3'd0);
      default: res_if.ready <= rx_tick[2];
    endcase
  end

  // both channels sampled at the edge, before any nonblocking update lands;
  // an item is noted before a result is checked, and the result always
  // belongs to an older item, so the order inside this block is safe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) mirror.take_item(item_if.payload);
      if (res_if.valid && res_if.ready) mirror.check_result(res_if.payload);
    end
  end

  function automatic item_t make_item(logic [2:0] kind, int c, int r);
    item_t it;
    it.kind = kind;
    it.col  = 12'(c);
    it.row  = 12'(r);
    return it;
  endfunction

  // random item: mostly pixel traffic near a hot spot so writes get read back,
  // plus whole-screen hits, wild coords, near-edge misses, unused kinds, rare wipes
  function automatic item_t rand_item();
    item_t      it;
    int unsigned pick;
    int         c;
    int         r;
    pick = $urandom_range(0, 99);
    if (pick < 25)      it.kind = KIND_SET;
    else if (pick < 40) it.kind = KIND_CLEAR;
    else if (pick < 55) it.kind = KIND_INVERT;
    else if (pick < 70) it.kind = KIND_READ_PIX;
    else if (pick < 90) it.kind = KIND_READ_BYTE;
    else if (pick < 94) it.kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    else if (pick < 95) it.kind = KIND_CLEAR_ALL;
    else                it.kind = KIND_SET;

    if ($urandom_range(0, 31) == 0) hot_col = $urandom_range(0, WIDTH - 8);
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      c = hot_col + $urandom_range(0, 7);
      r = $urandom_range(0, 15);
    end else if (pick < 7) begin
      c = $urandom_range(0, WIDTH - 1);
      r = $urandom_range(0, HEIGHT - 1);
    end else if (pick < 9) begin
      c = $signed(12'($urandom));
      r = $signed(12'($urandom));
    end else begin
      c = $urandom_range(0, WIDTH - 1);
      r = $urandom_range(0, HEIGHT - 1);
      case ($urandom_range(0, 3))
        0: c = -1;
        1: c = WIDTH;
        2: r = -1;
        default: r = HEIGHT;
      endcase
    end
    it.col = 12'(c);
    it.row = 12'(r);
    return it;
  endfunction

  // hold valid high from this edge until the engine takes the item
  task automatic push(item_t it);
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  // sender gap; payload keeps changing while valid is low
  task automatic idle(int n);
    item_if.valid <= 1'b0;
    repeat (n) begin
      item_if.payload <= make_item(3'($urandom), $urandom, $urandom);
      @(posedge clk_i);
    end
  endtask

  // stop sending until every owed result is back; looked at on the falling
  // edge so the check never races the monitor
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (mirror.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int burst_left;
    mirror = new();
    rst_ni          = 1'b0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    res_if.ready    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, page boundary, every kind, clipping on each edge
    push(make_item(KIND_READ_PIX, 0, 0));            // store starts blank
    push(make_item(KIND_SET, 0, 0));                 // origin is on screen
    push(make_item(KIND_READ_BYTE, 0, 0));
    push(make_item(KIND_SET, WIDTH - 1, HEIGHT - 1));
    push(make_item(KIND_READ_PIX, WIDTH - 1, HEIGHT - 1));
    push(make_item(KIND_INVERT, WIDTH - 1, HEIGHT - 1));
    push(make_item(KIND_INVERT, WIDTH - 1, HEIGHT - 2));
    push(make_item(KIND_CLEAR, WIDTH - 1, HEIGHT - 2));
    push(make_item(KIND_SET, 5, 7));                 // last row of page 0
    push(make_item(KIND_SET, 5, 8));                 // first row of page 1
    push(make_item(KIND_READ_BYTE, 5, 0));
    idle(3);
    push(make_item(KIND_SET, -1, 0));                // off each edge by one
    push(make_item(KIND_SET, WIDTH, 0));
    push(make_item(KIND_INVERT, 0, -1));
    push(make_item(KIND_CLEAR, 0, HEIGHT));
    push(make_item(KIND_READ_PIX, -2048, 2047));     // coordinate extremes
    push(make_item(KIND_READ_BYTE, 2047, -2048));
    push(make_item(KIND_SPARE_LO, 5, 8));            // unused kinds do nothing
    push(make_item(KIND_SPARE_HI, -1, -1));
    push(make_item(KIND_CLEAR_ALL, 2047, 2047));     // coordinates ignored
    push(make_item(KIND_READ_BYTE, 5, 0));
    push(make_item(KIND_READ_PIX, 0, 0));
    drain();

    // random traffic in bursts, with a full drain every so often
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      push(rand_item());
      if (i % 160 == 159) begin
        drain();
      end else if (--burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
      end
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    mirror.check_drained();

    $display("checked %0d results, %0d clipped; kinds set/clr/inv/rdpix/rdbyte/wipe/unused:",
             mirror.checked, mirror.clipped_seen);
    $display("  %0d/%0d/%0d/%0d/%0d/%0d/%0d, %0d errors",
             mirror.kind_count[KIND_SET], mirror.kind_count[KIND_CLEAR],
             mirror.kind_count[KIND_INVERT], mirror.kind_count[KIND_READ_PIX],
             mirror.kind_count[KIND_READ_BYTE], mirror.kind_count[KIND_CLEAR_ALL],
             mirror.kind_count[KIND_SPARE_LO] + mirror.kind_count[KIND_SPARE_HI],
             mirror.errors);
    if (mirror.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- paged_mono_framebuffer_engine_unit.f -----
rtl/pmfb_pkg.sv
rtl/pmfb_item_if.sv
rtl/pmfb_result_if.sv
rtl/pmfb_ram.sv
rtl/pmfb_decode.sv
rtl/paged_mono_framebuffer_engine_unit.sv
tb/tb_top.sv
